// ===== design/quaternion_between_vectors_unit_macros.svh =====
// Assertion helpers for the shortest-arc quaternion unit.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef QUATERNION_BETWEEN_VECTORS_UNIT_MACROS_SVH
`define QUATERNION_BETWEEN_VECTORS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QBV_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define QBV_CHECK_AFTER(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== design/qbv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qbv_pkg;

  // Width of every quaternion component on the result ports.
  localparam int OUT_BITS = 16;

  // Magnitudes are brought below 2**LIMIT_BITS before they are squared.
  localparam int LIMIT_BITS = 30;

  // Saturation limits of a result component, as 32-bit magnitudes.
  localparam logic [31:0] OUT_POS_LIM = 32'((1 << (OUT_BITS - 1)) - 1);
  localparam logic [31:0] OUT_NEG_LIM = 32'(1 << (OUT_BITS - 1));

  // Axis used to build the turn axis for opposite vectors.
  typedef enum logic [2:0] {
    AXIS_X = 3'b001,
    AXIS_Y = 3'b010,
    AXIS_Z = 3'b100
  } axis_t;

endpackage

`default_nettype wire

// ===== design/qbv_sqrt_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Integer square root, one root bit per register stage.
module qbv_sqrt_pipe #(
  parameter int RAD_BITS  = 64,
  parameter int SIDE_BITS = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [RAD_BITS-1:0]      in_rad,
  input  logic [SIDE_BITS-1:0]     in_side,
  output logic                     out_valid,
  output logic [RAD_BITS/2-1:0]    out_root,
  output logic [SIDE_BITS-1:0]     out_side
);

  localparam int ROOT_BITS = RAD_BITS / 2;

  logic                 valid_q [1:ROOT_BITS];
  logic [RAD_BITS-1:0]  rem_q   [1:ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q  [1:ROOT_BITS];
  logic [SIDE_BITS-1:0] side_q  [1:ROOT_BITS];

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
    localparam int B = ROOT_BITS - 1 - g;
    logic                 vin;
    logic [RAD_BITS-1:0]  rin;
    logic [ROOT_BITS-1:0] qin;
    logic [SIDE_BITS-1:0] sin;
    logic [RAD_BITS-1:0]  trial;

    if (g == 0) begin : g_first
      assign vin = in_valid;
      assign rin = in_rad;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = valid_q[g];
      assign rin = rem_q[g];
      assign qin = root_q[g];
      assign sin = side_q[g];
    end

    // Root bits below B are still zero, so the trial is (2r + 2^B) * 2^B.
    assign trial = (RAD_BITS'(qin) << (B + 1)) | (RAD_BITS'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[g+1] <= 1'b0;
      end else begin
        valid_q[g+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      side_q[g+1] <= sin;
      if (rin >= trial) begin
        rem_q[g+1]  <= rin - trial;
        root_q[g+1] <= qin | (ROOT_BITS'(1) << B);
      end else begin
        rem_q[g+1]  <= rin;
        root_q[g+1] <= qin;
      end
    end
  end

  assign out_valid = valid_q[ROOT_BITS];
  assign out_root  = root_q[ROOT_BITS];
  assign out_side  = side_q[ROOT_BITS];

endmodule

`default_nettype wire

// ===== design/qbv_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per register stage. The caller
// guarantees that the quotient fits in QUO_BITS.
module qbv_div_pipe #(
  parameter int NUM_BITS  = 45,
  parameter int DEN_BITS  = 31,
  parameter int QUO_BITS  = 15,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [NUM_BITS-1:0]  in_num,
  input  logic [DEN_BITS-1:0]  in_den,
  input  logic [SIDE_BITS-1:0] in_side,
  output logic                 out_valid,
  output logic [QUO_BITS-1:0]  out_quo,
  output logic [SIDE_BITS-1:0] out_side
);

  logic                 valid_q [1:QUO_BITS];
  logic [NUM_BITS-1:0]  rem_q   [1:QUO_BITS];
  logic [DEN_BITS-1:0]  den_q   [1:QUO_BITS];
  logic [QUO_BITS-1:0]  quo_q   [1:QUO_BITS];
  logic [SIDE_BITS-1:0] side_q  [1:QUO_BITS];

  for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
    localparam int I = QUO_BITS - 1 - g;
    logic                 vin;
    logic [NUM_BITS-1:0]  rin;
    logic [DEN_BITS-1:0]  din;
    logic [QUO_BITS-1:0]  qin;
    logic [SIDE_BITS-1:0] sin;
    logic [NUM_BITS-1:0]  trial;

    if (g == 0) begin : g_first
      assign vin = in_valid;
      assign rin = in_num;
      assign din = in_den;
      assign qin = '0;
      assign sin = in_side;
    end else begin : g_next
      assign vin = valid_q[g];
      assign rin = rem_q[g];
      assign din = den_q[g];
      assign qin = quo_q[g];
      assign sin = side_q[g];
    end

    assign trial = NUM_BITS'(din) << I;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[g+1] <= 1'b0;
      end else begin
        valid_q[g+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      den_q[g+1]  <= din;
      side_q[g+1] <= sin;
      if (rin >= trial) begin
        rem_q[g+1] <= rin - trial;
        quo_q[g+1] <= qin | (QUO_BITS'(1) << I);
      end else begin
        rem_q[g+1] <= rin;
        quo_q[g+1] <= qin;
      end
    end
  end

  assign out_valid = valid_q[QUO_BITS];
  assign out_quo   = quo_q[QUO_BITS];
  assign out_side  = side_q[QUO_BITS];

endmodule

`default_nettype wire

// ===== design/quaternion_between_vectors_unit.sv =====
// Shortest-arc rotation quaternion between two 3-vectors.
//
// Command channel: drive u_x..v_z and raise start; the beat is taken at
// every rising edge where start is high and busy is low. busy is always
// low, so a new beat may enter on every clock.
// Result channel: done is high for exactly one cycle per beat, with
// q_w..q_z (signed, QUAT_FRACTION_BITS fraction bits) and degenerate on
// the ports in that cycle. The receiver cannot stall; results come out
// in the order the beats went in.
// The result is taken at the edge that follows the rise of done. The
// depth is set by the two bit-per-stage square roots and the
// bit-per-stage dividers. Throughput is one beat per cycle.
// Synchronous reset clears every stage valid bit, so no result is lost
// or invented; beats in flight at reset are dropped.
// If u or v is the zero vector, degenerate is set and the identity
// quaternion is returned.
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_between_vectors_unit_macros.svh"

module quaternion_between_vectors_unit
  import qbv_pkg::*;
#(
  parameter int COMPONENT_BITS     = 16,
  parameter int QUAT_FRACTION_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_BITS-1:0] u_x,
  input  logic signed [COMPONENT_BITS-1:0] u_y,
  input  logic signed [COMPONENT_BITS-1:0] u_z,
  input  logic signed [COMPONENT_BITS-1:0] v_x,
  input  logic signed [COMPONENT_BITS-1:0] v_y,
  input  logic signed [COMPONENT_BITS-1:0] v_z,
  output logic                             done,
  output logic signed [OUT_BITS-1:0]       q_w,
  output logic signed [OUT_BITS-1:0]       q_x,
  output logic signed [OUT_BITS-1:0]       q_y,
  output logic signed [OUT_BITS-1:0]       q_z,
  output logic                             degenerate
);

  localparam int C     = COMPONENT_BITS;
  localparam int F     = QUAT_FRACTION_BITS;
  localparam int PW    = 2 * C;          // one signed product
  localparam int AW    = 2 * C + 2;      // dot, cross and w components
  localparam int NW    = 2 * C;          // squared vector length
  localparam int RADA  = 4 * C;          // |u|^2 * |v|^2
  localparam int ROOTA = 2 * C;
  localparam int LW    = LIMIT_BITS;
  localparam int SQW   = 2 * LW;
  localparam int RADB  = 2 * LW + 2;
  localparam int ROOTB = LW + 1;
  localparam int NUMW  = LW + F + 1;
  localparam int QB    = F + 1;
  localparam int SMAX  = (AW > LW) ? AW - LW : 0;
  localparam int SHW   = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
  localparam int SIDEA = 4 * AW + 2;
  localparam int SIDEB = 4 * LW + 5;
  localparam int LATENCY = 43 + 2 * C + F;
  localparam logic [QB-1:0] ONE_Q = QB'(1) << F;

  // Saturate a quotient magnitude to the result width and apply the sign.
  function automatic logic [OUT_BITS-1:0] to_out(input logic [QB-1:0] mag,
                                                 input logic neg);
    logic [31:0]         wide;
    logic [OUT_BITS-1:0] m16;
    wide = 32'(mag);
    if (!neg && wide > OUT_POS_LIM) wide = OUT_POS_LIM;
    if (neg && wide > OUT_NEG_LIM) wide = OUT_NEG_LIM;
    m16 = wide[OUT_BITS-1:0];
    return neg ? (~m16 + 1'b1) : m16;
  endfunction

  localparam logic [OUT_BITS-1:0] ID_W = to_out(ONE_Q, 1'b0);

  // The pipeline never holds off a beat.
  assign busy = 1'b0;

  // Stage 1: capture the command beat.
  logic                v1;
  logic signed [C-1:0] ux1, uy1, uz1, vx1, vy1, vz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ux1 <= u_x;
    uy1 <= u_y;
    uz1 <= u_z;
    vx1 <= v_x;
    vy1 <= v_y;
    vz1 <= v_z;
  end

  // Stage 2: all component products in parallel.
  logic                 v2, zero2;
  logic signed [PW-1:0] pd0, pd1, pd2;
  logic signed [PW-1:0] pc0, pc1, pc2, pc3, pc4, pc5;
  logic signed [PW-1:0] pu0, pu1, pu2, pv0, pv1, pv2;
  logic signed [C-1:0]  ux2, uy2, uz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pd0 <= ux1 * vx1;
    pd1 <= uy1 * vy1;
    pd2 <= uz1 * vz1;
    pc0 <= uy1 * vz1;
    pc1 <= uz1 * vy1;
    pc2 <= uz1 * vx1;
    pc3 <= ux1 * vz1;
    pc4 <= ux1 * vy1;
    pc5 <= uy1 * vx1;
    pu0 <= ux1 * ux1;
    pu1 <= uy1 * uy1;
    pu2 <= uz1 * uz1;
    pv0 <= vx1 * vx1;
    pv1 <= vy1 * vy1;
    pv2 <= vz1 * vz1;
    zero2 <= (ux1 == '0 && uy1 == '0 && uz1 == '0) ||
             (vx1 == '0 && vy1 == '0 && vz1 == '0);
    ux2 <= ux1;
    uy2 <= uy1;
    uz2 <= uz1;
  end

  // Stage 3: dot product, cross product and squared lengths.
  logic                 v3, zero3;
  logic signed [AW-1:0] d3, cx3, cy3, cz3;
  logic [NW-1:0]        nu3, nv3;
  logic signed [C-1:0]  ux3, uy3, uz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d3  <= AW'(pd0) + AW'(pd1) + AW'(pd2);
    cx3 <= AW'(pc0) - AW'(pc1);
    cy3 <= AW'(pc2) - AW'(pc3);
    cz3 <= AW'(pc4) - AW'(pc5);
    nu3 <= NW'($unsigned(pu0)) + NW'($unsigned(pu1)) + NW'($unsigned(pu2));
    nv3 <= NW'($unsigned(pv0)) + NW'($unsigned(pv1)) + NW'($unsigned(pv2));
    zero3 <= zero2;
    ux3 <= ux2;
    uy3 <= uy2;
    uz3 <= uz2;
  end

  // Stage 4: length product, and the choice of vector part. Exactly
  // opposite vectors turn about u crossed with its smallest axis.
  logic                 v4;
  logic [RADA-1:0]      prod4;
  logic [SIDEA-1:0]     side4;
  logic                 opp;
  logic [C-1:0]         ax, ay, az;
  axis_t                axis;
  logic signed [AW-1:0] e1, e2, e3;

  always_comb begin
    opp = (cx3 == '0) && (cy3 == '0) && (cz3 == '0) && (d3 < 0);
    ax  = ux3[C-1] ? $unsigned(-ux3) : $unsigned(ux3);
    ay  = uy3[C-1] ? $unsigned(-uy3) : $unsigned(uy3);
    az  = uz3[C-1] ? $unsigned(-uz3) : $unsigned(uz3);
    if (ax < ay) begin
      axis = (ax < az) ? AXIS_X : AXIS_Z;
    end else begin
      axis = (ay < az) ? AXIS_Y : AXIS_Z;
    end
    unique case (axis)
      AXIS_X: begin
        e1 = '0;
        e2 = AW'(uz3);
        e3 = -AW'(uy3);
      end
      AXIS_Y: begin
        e1 = -AW'(uz3);
        e2 = '0;
        e3 = AW'(ux3);
      end
      AXIS_Z: begin
        e1 = AW'(uy3);
        e2 = -AW'(ux3);
        e3 = '0;
      end
      default: begin
        e1 = '0;
        e2 = '0;
        e3 = '0;
      end
    endcase
    if (!opp) begin
      e1 = cx3;
      e2 = cy3;
      e3 = cz3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod4 <= RADA'(nu3) * RADA'(nv3);
    side4 <= {zero3, opp, d3, e1, e2, e3};
  end

  // Square root of the length product: k = floor(|u| |v|).
  logic             v5;
  logic [ROOTA-1:0] k5;
  logic [SIDEA-1:0] side5;

  qbv_sqrt_pipe #(
    .RAD_BITS  (RADA),
    .SIDE_BITS (SIDEA)
  ) u_root_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_rad    (prod4),
    .in_side   (side4),
    .out_valid (v5),
    .out_root  (k5),
    .out_side  (side5)
  );

  logic                 zero5, opp5;
  logic signed [AW-1:0] d5, a5 [4];

  assign {zero5, opp5, d5, a5[1], a5[2], a5[3]} = side5;
  assign a5[0] = opp5 ? '0 : d5 + $signed({2'b00, k5});

  // Stage 6: magnitudes and signs of the unnormalized quaternion.
  logic          v6, zero6;
  logic [AW-1:0] m6 [4];
  logic [3:0]    neg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m6[i]   <= a5[i][AW-1] ? $unsigned(-a5[i]) : $unsigned(a5[i]);
      neg6[i] <= a5[i][AW-1];
    end
    zero6 <= zero5;
  end

  // Stage 7: largest magnitude.
  logic          v7, zero7;
  logic [AW-1:0] m7 [4];
  logic [AW-1:0] top7, top_lo, top_hi;
  logic [3:0]    neg7;

  assign top_lo = (m6[0] > m6[1]) ? m6[0] : m6[1];
  assign top_hi = (m6[2] > m6[3]) ? m6[2] : m6[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    top7  <= (top_lo > top_hi) ? top_lo : top_hi;
    m7    <= m6;
    neg7  <= neg6;
    zero7 <= zero6;
  end

  // Stage 8: smallest right shift that brings every magnitude below the
  // squaring limit, then the shift itself.
  logic           v8, zero8;
  logic [LW-1:0]  ms8 [4];
  logic [3:0]     neg8;
  logic [SHW-1:0] sh;

  always_comb begin
    sh = '0;
    for (int s = SMAX; s >= 0; s--) begin
      if ((top7 >> s) < (AW + 1)'(1) << LW) sh = SHW'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      ms8[i] <= LW'(m7[i] >> sh);
    end
    neg8  <= neg7;
    zero8 <= zero7;
  end

  // Stage 9: squares. Stage 10: their sum.
  logic           v9, zero9, v10, zero10;
  logic [SQW-1:0] sq9 [4];
  logic [LW-1:0]  ms9 [4], ms10 [4];
  logic [3:0]     neg9, neg10;
  logic [RADB-1:0] sum10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq9[i] <= SQW'(ms8[i]) * SQW'(ms8[i]);
    end
    ms9    <= ms8;
    neg9   <= neg8;
    zero9  <= zero8;
    sum10  <= RADB'(sq9[0]) + RADB'(sq9[1]) + RADB'(sq9[2]) + RADB'(sq9[3]);
    ms10   <= ms9;
    neg10  <= neg9;
    zero10 <= zero9;
  end

  // Square root of the sum of squares: the norm n.
  logic             v11;
  logic [ROOTB-1:0] n11;
  logic [SIDEB-1:0] side11;
  logic             zero11;
  logic [3:0]       neg11;
  logic [LW-1:0]    ms11 [4];

  qbv_sqrt_pipe #(
    .RAD_BITS  (RADB),
    .SIDE_BITS (SIDEB)
  ) u_root_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10),
    .in_rad    (sum10),
    .in_side   ({zero10, neg10, ms10[0], ms10[1], ms10[2], ms10[3]}),
    .out_valid (v11),
    .out_root  (n11),
    .out_side  (side11)
  );

  assign {zero11, neg11, ms11[0], ms11[1], ms11[2], ms11[3]} = side11;

  // Stage 12: dividends with half the divisor added, for round half up.
  logic             v12, zero12, nz12;
  logic [NUMW-1:0]  num12 [4];
  logic [ROOTB-1:0] den12;
  logic [3:0]       neg12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      num12[i] <= (NUMW'(ms11[i]) << F) + NUMW'(n11 >> 1);
    end
    den12  <= n11;
    nz12   <= (n11 == '0);
    neg12  <= neg11;
    zero12 <= zero11;
  end

  // Four dividers side by side. Lane 0 also carries the special-case flags.
  logic          vq [4];
  logic [QB-1:0] quo [4];
  logic [2:0]    side_q0;
  logic          neg_q1, neg_q2, neg_q3;

  qbv_div_pipe #(
    .NUM_BITS (NUMW), .DEN_BITS (ROOTB), .QUO_BITS (QB), .SIDE_BITS (3)
  ) u_div_w (
    .clk (clk), .rst (rst), .in_valid (v12), .in_num (num12[0]), .in_den (den12),
    .in_side ({zero12, nz12, neg12[0]}),
    .out_valid (vq[0]), .out_quo (quo[0]), .out_side (side_q0)
  );

  qbv_div_pipe #(
    .NUM_BITS (NUMW), .DEN_BITS (ROOTB), .QUO_BITS (QB), .SIDE_BITS (1)
  ) u_div_x (
    .clk (clk), .rst (rst), .in_valid (v12), .in_num (num12[1]), .in_den (den12),
    .in_side (neg12[1]),
    .out_valid (vq[1]), .out_quo (quo[1]), .out_side (neg_q1)
  );

  qbv_div_pipe #(
    .NUM_BITS (NUMW), .DEN_BITS (ROOTB), .QUO_BITS (QB), .SIDE_BITS (1)
  ) u_div_y (
    .clk (clk), .rst (rst), .in_valid (v12), .in_num (num12[2]), .in_den (den12),
    .in_side (neg12[2]),
    .out_valid (vq[2]), .out_quo (quo[2]), .out_side (neg_q2)
  );

  qbv_div_pipe #(
    .NUM_BITS (NUMW), .DEN_BITS (ROOTB), .QUO_BITS (QB), .SIDE_BITS (1)
  ) u_div_z (
    .clk (clk), .rst (rst), .in_valid (v12), .in_num (num12[3]), .in_den (den12),
    .in_side (neg12[3]),
    .out_valid (vq[3]), .out_quo (quo[3]), .out_side (neg_q3)
  );

  // Output register. A zero input vector gives the identity; a zero norm
  // gives all-zero components.
  logic [OUT_BITS-1:0] qw_r, qx_r, qy_r, qz_r;
  logic                all_valid;
  logic                is_identity;

  assign all_valid = vq[0] && vq[1] && vq[2] && vq[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= all_valid;
    end
  end

  always_ff @(posedge clk) begin
    degenerate <= side_q0[2];
    if (side_q0[2]) begin
      qw_r <= ID_W;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else if (side_q0[1]) begin
      qw_r <= '0;
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
    end else begin
      qw_r <= to_out(quo[0], side_q0[0]);
      qx_r <= to_out(quo[1], neg_q1);
      qy_r <= to_out(quo[2], neg_q2);
      qz_r <= to_out(quo[3], neg_q3);
    end
  end

  assign q_w = $signed(qw_r);
  assign q_x = $signed(qx_r);
  assign q_y = $signed(qy_r);
  assign q_z = $signed(qz_r);

  assign is_identity = (qw_r == ID_W) && (qx_r == '0) && (qy_r == '0) && (qz_r == '0);

  // Every accepted beat comes out after the fixed pipeline depth.
  `QBV_CHECK_AFTER(a_latency, start && !busy, LATENCY, done, "result beat missing")
  // Zero vectors give exactly the identity.
  `QBV_CHECK(a_identity, done && degenerate, is_identity, "degenerate result not identity")
  // The scalar part d + |u||v| is never negative.
  `QBV_CHECK(a_w_sign, done && !degenerate, !qw_r[OUT_BITS-1], "negative scalar part")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the shortest-arc quaternion unit.
//
// Each test task builds pairs of vectors u and v and hands them to one shared
// task that sends a beat. The checker process computes the expected
// quaternion and queues it when the beat is accepted, and compares every
// done cycle, field by field, against the oldest queued quaternion.
//
// The block never asserts backpressure in practice, but the sender still
// honors busy. The receiver cannot stall, so only the sender idles, and only
// in part of the run.
module tb_top;
  import qbv_pkg::*;

  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = 14;
  // Cycles from the accepting edge to done; the final drain adds slack.
  localparam int PIPE_CYCLES = 43 + 2 * COMP_BITS + FRAC_BITS;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] x;
    logic signed [COMP_BITS-1:0] y;
    logic signed [COMP_BITS-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] w;
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
    logic                       degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  vec_t u_in = '0;
  vec_t v_in = '0;
  logic done;
  logic signed [OUT_BITS-1:0] q_w, q_x, q_y, q_z;
  logic degenerate;

  // The quaternions still owed by the block, oldest first.
  quat_t owed_quats[$];
  int mismatches = 0;
  // When set, the sender never inserts idle cycles.
  bit steady_send = 1'b0;

  always #4 clk = ~clk;

  quaternion_between_vectors_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .u_x(u_in.x), .u_y(u_in.y), .u_z(u_in.z),
    .v_x(v_in.x), .v_y(v_in.y), .v_z(v_in.z),
    .done(done), .q_w(q_w), .q_x(q_x), .q_y(q_y), .q_z(q_z),
    .degenerate(degenerate)
  );

  // Integer square root, floor, of a value up to 128 bits.
  function automatic logic [63:0] floor_root(logic [127:0] val);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= val) r = c;
    end
    return r;
  endfunction

  // Scales a 4-vector to unit length with FRAC_BITS fraction bits.
  // Magnitudes are first shifted down until the largest fits in LIMIT_BITS,
  // then each component is divided by the root of the sum of squares with
  // round half up on the magnitude and saturated to the output range.
  function automatic quat_t unit_quat(longint a[4]);
    logic [63:0] mag[4];
    logic [63:0] top, sum, n, q, lim;
    logic signed [OUT_BITS-1:0] comp[4];
    int sh;
    quat_t res;
    top = '0;
    sum = '0;
    sh = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
      if (mag[i] > top) top = mag[i];
    end
    while (sh < 63 && (top >> sh) >= (64'd1 << LIMIT_BITS)) sh++;
    for (int i = 0; i < 4; i++) begin
      mag[i] = mag[i] >> sh;
      sum += mag[i] * mag[i];
    end
    n = floor_root({64'd0, sum});
    for (int i = 0; i < 4; i++) begin
      q = (n != 0) ? ((mag[i] << FRAC_BITS) + (n >> 1)) / n : 64'd0;
      lim = a[i] < 0 ? 64'(OUT_NEG_LIM) : 64'(OUT_POS_LIM);
      if (q > lim) q = lim;
      comp[i] = a[i] < 0 ? OUT_BITS'(-q) : OUT_BITS'(q);
    end
    res.w = comp[0];
    res.x = comp[1];
    res.y = comp[2];
    res.z = comp[3];
    res.degen = 1'b0;
    return res;
  endfunction

  // The rotation quaternion that turns u onto v along the shortest arc.
  function automatic quat_t shortest_arc(vec_t u, vec_t v);
    longint ux, uy, uz, vx, vy, vz, d, cx, cy, cz;
    longint a[4];
    logic [63:0] nu, nv, ax, ay, az;
    axis_t axis;
    quat_t res;
    ux = u.x; uy = u.y; uz = u.z;
    vx = v.x; vy = v.y; vz = v.z;
    // A zero vector has no direction: the block flags it and returns identity.
    if ((ux == 0 && uy == 0 && uz == 0) || (vx == 0 && vy == 0 && vz == 0)) begin
      res.w = OUT_BITS'(1 << FRAC_BITS);
      res.x = '0;
      res.y = '0;
      res.z = '0;
      res.degen = 1'b1;
      return res;
    end
    d = ux * vx + uy * vy + uz * vz;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    if (cx == 0 && cy == 0 && cz == 0 && d < 0) begin
      // Opposite vectors: a half turn about u crossed with the axis of u's
      // smallest component, ties going toward the later axis.
      ax = ux < 0 ? -ux : ux;
      ay = uy < 0 ? -uy : uy;
      az = uz < 0 ? -uz : uz;
      axis = ax < ay ? (ax < az ? AXIS_X : AXIS_Z) : (ay < az ? AXIS_Y : AXIS_Z);
      a[0] = 0;
      case (axis)
        AXIS_X: begin
          a[1] = 0; a[2] = uz; a[3] = -uy;
        end
        AXIS_Y: begin
          a[1] = -uz; a[2] = 0; a[3] = ux;
        end
        default: begin
          a[1] = uy; a[2] = -ux; a[3] = 0;
        end
      endcase
    end else begin
      nu = 64'(ux * ux + uy * uy + uz * uz);
      nv = 64'(vx * vx + vy * vy + vz * vz);
      a[0] = d + longint'(floor_root({64'd0, nu} * {64'd0, nv}));
      a[1] = cx;
      a[2] = cy;
      a[3] = cz;
    end
    return unit_quat(a);
  endfunction

  // Sends one beat and keeps start high afterward, so back-to-back beats
  // never lower and raise start in the same step. Occasionally idles first.
  task automatic send_pair(vec_t u, vec_t v);
    if (!steady_send && $urandom_range(99) < 3) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    @(negedge clk);
    u_in = u;
    v_in = v;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Lowers start and holds off until the block has delivered everything.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (owed_quats.size() != 0) @(posedge clk);
  endtask

  function automatic vec_t vec_of(int x, int y, int z);
    vec_t r;
    r.x = COMP_BITS'(x);
    r.y = COMP_BITS'(y);
    r.z = COMP_BITS'(z);
    return r;
  endfunction

  function automatic vec_t rand_vec();
    return vec_of($urandom, $urandom, $urandom);
  endfunction

  // Small components reach the near-zero and integer-tie corners more often.
  function automatic vec_t rand_small_vec();
    return vec_of($urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4);
  endfunction

  // Extremes of the fields, zero vectors, and the opposite-vector axis ties.
  task automatic test_directed();
    send_pair(vec_of(0, 0, 0), vec_of(0, 0, 0));
    send_pair(vec_of(0, 0, 0), vec_of(5, -3, 2));
    send_pair(vec_of(7, 1, -9), vec_of(0, 0, 0));
    send_pair(vec_of(-32768, -32768, -32768), vec_of(32767, 32767, 32767));
    send_pair(vec_of(-32768, -32768, -32768), vec_of(-32768, -32768, -32768));
    send_pair(vec_of(32767, 32767, 32767), vec_of(32767, 32767, 32767));
    send_pair(vec_of(-32768, 0, 0), vec_of(0, 32767, 0));
    send_pair(vec_of(32767, -32768, 32767), vec_of(-32768, 32767, -32768));
    send_pair(vec_of(256, 0, 0), vec_of(-256, 0, 0));
    send_pair(vec_of(0, 256, 0), vec_of(0, -1, 0));
    send_pair(vec_of(0, 0, -1), vec_of(0, 0, 32767));
    send_pair(vec_of(1, 1, 1), vec_of(-1, -1, -1));
    send_pair(vec_of(0, 5, 5), vec_of(0, -5, -5));
    send_pair(vec_of(3, 1, 3), vec_of(-6, -2, -6));
    send_pair(vec_of(2, 2, 1), vec_of(-2, -2, -1));
    send_pair(vec_of(-4, 4, 9), vec_of(4, -4, -9));
    send_pair(vec_of(1, 2, 3), vec_of(2, 4, 6));
    send_pair(vec_of(1, 0, 0), vec_of(0, 1, 0));
    send_pair(vec_of(1, 0, 0), vec_of(-1, 1, 0));
    send_pair(vec_of(32767, 1, 0), vec_of(-32768, 0, 0));
  endtask

  // Exactly opposite pairs with random direction and scale.
  task automatic test_opposite(int count);
    vec_t u;
    int k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) begin
        u = vec_of($urandom_range(510) - 255, $urandom_range(510) - 255,
                   $urandom_range(510) - 255);
        k = $urandom_range(128, 1);
        send_pair(u, vec_of(-k * u.x, -k * u.y, -k * u.z));
      end else begin
        u = vec_of($urandom_range(65534) - 32767, $urandom_range(65534) - 32767,
                   $urandom_range(65534) - 32767);
        send_pair(u, vec_of(-u.x, -u.y, -u.z));
      end
    end
  endtask

  // The bulk of the run: full-range pairs mixed with the rarer shapes.
  task automatic test_random(int count);
    vec_t u;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_pair(rand_vec(), rand_vec());
      end else if (pick < 75) begin
        send_pair(rand_small_vec(), rand_small_vec());
      end else if (pick < 85) begin
        // Parallel, same direction.
        u = rand_small_vec();
        send_pair(u, vec_of(u.x * 100, u.y * 100, u.z * 100));
      end else if (pick < 95) begin
        test_opposite(1);
      end else if (pick < 98) begin
        send_pair(vec_of(0, 0, 0), rand_vec());
      end else begin
        send_pair(rand_vec(), vec_of(0, 0, 0));
      end
    end
  endtask

  // Pushes the owed quaternion at the accepting edge and checks every done
  // cycle. Both happen on the same rising edge, with pushes first.
  always @(posedge clk) begin
    quat_t want;
    quat_t got;
    if (!rst && start && !busy) owed_quats.push_back(shortest_arc(u_in, v_in));
    if (!rst && done) begin
      got = {q_w, q_x, q_y, q_z, degenerate};
      if (owed_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = owed_quats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want w=%0d x=%0d y=%0d z=%0d deg=%b,",
                     want.w, want.x, want.y, want.z, want.degen,
                     " got w=%0d x=%0d y=%0d z=%0d deg=%b",
                     got.w, got.x, got.y, got.z, got.degen);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    drain_results();
    test_opposite(100);
    steady_send = 1'b1;
    test_random(400);
    steady_send = 1'b0;
    drain_results();
    test_random(1030);
    drain_results();
    repeat (PIPE_CYCLES + 20) @(posedge clk);
    if (mismatches == 0 && owed_quats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== quaternion_between_vectors_unit.f =====
+incdir+design
design/qbv_pkg.sv
design/qbv_sqrt_pipe.sv
design/qbv_div_pipe.sv
design/quaternion_between_vectors_unit.sv
verif/tb_top.sv
